// File: hdl/per_cpu_page_free_list_allocator_top_defines.svh
// assertion macros used by the top-level rtl file
`ifndef PER_CPU_PAGE_FREE_LIST_ALLOCATOR_TOP_DEFINES_SVH
`define PER_CPU_PAGE_FREE_LIST_ALLOCATOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define PCPA_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define PCPA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PCPA_ASSERT(lbl, clk, rstn, prop, msg)
`define PCPA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: hdl/pcpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pcpa_pkg;

    localparam int ADDR_W = 32;
    localparam int CPU_FIELD_W = 3;
    localparam int STATUS_W = 2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_PAGE  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_ADDR = 2'd2;

    localparam logic CFG_REGION_LOW  = 1'b0;
    localparam logic CFG_REGION_HIGH = 1'b1;

    typedef struct packed {
        logic                   op;
        logic [CPU_FIELD_W-1:0] cpu;
        logic [ADDR_W-1:0]      page_addr;
    } in_t;

    typedef struct packed {
        logic [ADDR_W-1:0]   alloc_addr;
        logic [STATUS_W-1:0] status;
        logic                stolen;
    } out_t;

endpackage

`default_nettype wire

// File: hdl/per_cpu_page_free_list_allocator_top.sv
// result path: input transfer in IDLE, DECODE, POP (allocate with a page only), EMIT into the output register
// one item at a time: a new input is taken only in IDLE, after the previous item has been emitted
// allocate adds the next-link memory read in POP before the head update
// a pending result in the output register does not block the next input transfer
// reset: synchronous active-low, all lists empty, region registers zero, no clearing pass
`timescale 1ns / 1ps
`default_nettype none
`include "per_cpu_page_free_list_allocator_top_defines.svh"

module per_cpu_page_free_list_allocator_top #(
    parameter int NUM_CPUS   = 8,
    parameter int NUM_PAGES  = 32768,
    parameter int PAGE_BYTES = 4096
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire pcpa_pkg::in_t s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output pcpa_pkg::out_t     m_data,
    input  wire logic          cfg_we,
    input  wire logic          cfg_index,
    input  wire logic [31:0]   cfg_wdata
);

    import pcpa_pkg::*;

    localparam int PB_SHIFT = $clog2(PAGE_BYTES);
    localparam int IDX_W = $clog2(NUM_PAGES);
    localparam int HEAD_W = $clog2(NUM_PAGES + 1);
    localparam int CPU_W = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int OFF_W = IDX_W + PB_SHIFT;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_DECODE = 4'b0010,
        ST_POP    = 4'b0100,
        ST_EMIT   = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [31:0] region_low_reg, region_low_next;
    logic [31:0] region_high_reg, region_high_next;
    logic [32:0] base_reg, base_next;

    logic [HEAD_W-1:0] head_reg [NUM_CPUS];
    logic [HEAD_W-1:0] head_next [NUM_CPUS];

    logic              op_reg, op_next;
    logic [CPU_W-1:0]  cpu_reg, cpu_next;
    logic [31:0]       addr_reg, addr_next;
    logic [CPU_W-1:0]  sel_reg, sel_next;
    logic [HEAD_W-1:0] pop_h_reg, pop_h_next;
    logic              stolen_reg, stolen_next;
    out_t              res_reg, res_next;
    out_t              m_data_reg, m_data_next;
    logic              m_valid_reg, m_valid_next;

    logic              chk_ok;
    logic [IDX_W-1:0]  chk_idx;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [HEAD_W-1:0] mem_wdata;
    logic              mem_re;
    logic [IDX_W-1:0]  mem_raddr;
    logic [HEAD_W-1:0] mem_rdata;

    logic [6:0]          cpu_mod;
    logic [NUM_CPUS-1:0] nonempty;
    logic [2*NUM_CPUS-1:0] dbl;
    logic [2*NUM_CPUS-1:0] rot_full;
    logic [NUM_CPUS-1:0] rot;
    logic [NUM_CPUS-1:0] cand;
    logic [NUM_CPUS-1:0] low1;
    logic [CPU_W-1:0]    steal_off;
    logic [CPU_W:0]      steal_sum;
    logic [CPU_W-1:0]    steal_cpu;
    logic [HEAD_W-1:0]   h_m1;
    logic [HEAD_W-1:0]   pop_m1;
    logic [OFF_W-1:0]    page_off;
    logic [63:0]         addr_sum;

    pcpa_addr_check #(
        .NUM_PAGES  (NUM_PAGES),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_check (
        .page_addr   (addr_reg),
        .region_low  (region_low_reg),
        .region_high (region_high_reg),
        .base        (base_reg),
        .ok          (chk_ok),
        .idx         (chk_idx)
    );

    pcpa_link_ram #(
        .DEPTH  (NUM_PAGES),
        .DATA_W (HEAD_W)
    ) u_link_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // cpu index folded into range
    always_comb begin
        cpu_mod = {4'd0, s_data.cpu};
        for (int k = 0; k < 8; k++) begin
            if (cpu_mod >= 7'(NUM_CPUS)) begin
                cpu_mod = cpu_mod - 7'(NUM_CPUS);
            end
        end
    end

    // round-robin pick of the first non-empty list after the own one
    always_comb begin
        for (int i = 0; i < NUM_CPUS; i++) begin
            nonempty[i] = (head_reg[i] != '0);
        end
        dbl      = {nonempty, nonempty};
        rot_full = dbl >> cpu_reg;
        rot      = rot_full[NUM_CPUS-1:0];
        cand     = rot & ~NUM_CPUS'(1);
        low1     = cand & (~cand + NUM_CPUS'(1));
        steal_off = '0;
        for (int i = 0; i < NUM_CPUS; i++) begin
            if (low1[i]) begin
                steal_off = steal_off | CPU_W'(i);
            end
        end
        steal_sum = {1'b0, cpu_reg} + {1'b0, steal_off};
        if (steal_sum >= (CPU_W+1)'(NUM_CPUS)) begin
            steal_cpu = CPU_W'(steal_sum - (CPU_W+1)'(NUM_CPUS));
        end else begin
            steal_cpu = steal_sum[CPU_W-1:0];
        end
    end

    always_comb begin
        pop_m1   = pop_h_reg - HEAD_W'(1);
        page_off = {pop_m1[IDX_W-1:0], PB_SHIFT'(0)};
        addr_sum = 64'(base_reg) + 64'(page_off);
    end

    always_comb begin
        state_next       = state_reg;
        region_low_next  = region_low_reg;
        region_high_next = region_high_reg;
        base_next        = base_reg;
        for (int i = 0; i < NUM_CPUS; i++) begin
            head_next[i] = head_reg[i];
        end
        op_next      = op_reg;
        cpu_next     = cpu_reg;
        addr_next    = addr_reg;
        sel_next     = sel_reg;
        pop_h_next   = pop_h_reg;
        stolen_next  = stolen_reg;
        res_next     = res_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg;
        mem_we       = 1'b0;
        mem_waddr    = chk_idx;
        mem_wdata    = head_reg[cpu_reg];
        mem_re       = 1'b0;
        h_m1         = '0;
        mem_raddr    = '0;

        if (cfg_we) begin
            case (cfg_index)
                CFG_REGION_LOW: begin
                    region_low_next = cfg_wdata;
                    base_next = ({1'b0, cfg_wdata} + 33'(PAGE_BYTES - 1))
                              & ~33'(PAGE_BYTES - 1);
                end
                CFG_REGION_HIGH: begin
                    region_high_next = cfg_wdata;
                end
                default: begin
                end
            endcase
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_next    = s_data.op;
                    cpu_next   = CPU_W'(cpu_mod);
                    addr_next  = s_data.page_addr;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (op_reg == OP_FREE) begin
                    if (chk_ok) begin
                        mem_we             = 1'b1;
                        head_next[cpu_reg] = HEAD_W'(chk_idx) + HEAD_W'(1);
                        res_next           = '{alloc_addr: '0, status: STATUS_OK, stolen: 1'b0};
                    end else begin
                        res_next = '{alloc_addr: '0, status: STATUS_BAD_ADDR, stolen: 1'b0};
                    end
                    state_next = ST_EMIT;
                end else if (rot[0] || (cand != '0)) begin
                    sel_next    = rot[0] ? cpu_reg : steal_cpu;
                    stolen_next = !rot[0];
                    pop_h_next  = head_reg[sel_next];
                    h_m1        = pop_h_next - HEAD_W'(1);
                    mem_raddr   = h_m1[IDX_W-1:0];
                    mem_re      = 1'b1;
                    state_next  = ST_POP;
                end else begin
                    res_next   = '{alloc_addr: '0, status: STATUS_NO_PAGE, stolen: 1'b0};
                    state_next = ST_EMIT;
                end
            end
            ST_POP: begin
                head_next[sel_reg] = mem_rdata;
                res_next = '{alloc_addr: addr_sum[31:0], status: STATUS_OK,
                             stolen: stolen_reg};
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next  = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            region_low_reg  <= '0;
            region_high_reg <= '0;
            base_reg        <= '0;
            m_valid_reg     <= 1'b0;
            for (int i = 0; i < NUM_CPUS; i++) begin
                head_reg[i] <= '0;
            end
        end else begin
            state_reg       <= state_next;
            region_low_reg  <= region_low_next;
            region_high_reg <= region_high_next;
            base_reg        <= base_next;
            m_valid_reg     <= m_valid_next;
            for (int i = 0; i < NUM_CPUS; i++) begin
                head_reg[i] <= head_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        cpu_reg    <= cpu_next;
        addr_reg   <= addr_next;
        sel_reg    <= sel_next;
        pop_h_reg  <= pop_h_next;
        stolen_reg <= stolen_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    `PCPA_ASSERT(a_accept_to_decode, aclk, aresetn, (s_valid && s_ready) |=> (state_reg == ST_DECODE), "transfer not followed by decode")
    `PCPA_ASSERT(a_write_on_free_only, aclk, aresetn, mem_we |-> (state_reg == ST_DECODE && op_reg == OP_FREE), "link write outside free decode")
    `PCPA_ASSERT(a_pop_after_decode, aclk, aresetn, (state_reg == ST_POP) |-> ($past(state_reg) == ST_DECODE && op_reg == OP_ALLOC), "pop without alloc decode")
    `PCPA_ASSERT(a_stolen_only_ok, aclk, aresetn, m_valid_reg |-> !(m_data_reg.stolen && m_data_reg.status != STATUS_OK), "stolen flag on failed result")

endmodule

`default_nettype wire

// File: hdl/pcpa_link_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module pcpa_link_ram #(
    parameter int DEPTH  = 32768,
    parameter int DATA_W = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [DATA_W-1:0]        wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: hdl/pcpa_addr_check.sv
`timescale 1ns / 1ps
`default_nettype none

module pcpa_addr_check #(
    parameter int NUM_PAGES  = 32768,
    parameter int PAGE_BYTES = 4096
) (
    input  wire logic [31:0]                  page_addr,
    input  wire logic [31:0]                  region_low,
    input  wire logic [31:0]                  region_high,
    input  wire logic [32:0]                  base,
    output logic                              ok,
    output logic      [$clog2(NUM_PAGES)-1:0] idx
);

    import pcpa_pkg::*;

    localparam int PB_SHIFT = $clog2(PAGE_BYTES);
    localparam int IDX_W = $clog2(NUM_PAGES);

    logic        aligned;
    logic        ge_low;
    logic        lt_high;
    logic        ge_base;
    logic        in_cap;
    logic [32:0] diff;
    logic [32:0] pg;

    always_comb begin
        aligned = (page_addr[PB_SHIFT-1:0] == '0);
        ge_low  = (page_addr >= region_low);
        lt_high = (page_addr < region_high);
        ge_base = ({1'b0, page_addr} >= base);
        diff    = {1'b0, page_addr} - base;
        pg      = diff >> PB_SHIFT;
        in_cap  = (pg < 33'(NUM_PAGES));
        ok      = aligned && ge_low && lt_high && ge_base && in_cap;
        idx     = pg[IDX_W-1:0];
    end

endmodule

`default_nettype wire

// File: bench/page_alloc_checker.sv
`timescale 1ns / 1ps

module page_alloc_checker #(
    parameter int NUM_CPUS   = 8,
    parameter int NUM_PAGES  = 32768,
    parameter int PAGE_BYTES = 4096
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    input  logic           s_ready,
    input  pcpa_pkg::in_t  s_data,
    input  logic           m_valid,
    input  logic           m_ready,
    input  pcpa_pkg::out_t m_data,
    input  logic           cfg_we,
    input  logic           cfg_index,
    input  logic [31:0]    cfg_wdata,
    output int             mismatches,
    output int             pending_results
);
    import pcpa_pkg::*;

    logic [31:0] region_low;
    logic [31:0] region_high;
    // list heads and links hold page number + 1, zero marks an empty list / end of list
    logic [15:0] list_head [NUM_CPUS];
    logic [15:0] next_link [NUM_PAGES];
    out_t        expected_results [$];

    function automatic logic [15:0] take_head(input int c);
        logic [15:0] h;
        h = list_head[c];
        if (h != 16'd0 && h <= NUM_PAGES) begin
            list_head[c] = next_link[h - 16'd1];
            return h;
        end
        return 16'd0;
    endfunction

    function automatic out_t serve_request(input in_t req);
        out_t        rsp;
        logic [32:0] base;
        logic [32:0] addr;
        logic [32:0] idx;
        logic [15:0] h;
        int          c;
        rsp  = '0;
        base = ({1'b0, region_low} + 33'(PAGE_BYTES - 1)) & ~33'(PAGE_BYTES - 1);
        addr = {1'b0, req.page_addr};
        c    = int'(req.cpu) % NUM_CPUS;
        if (req.op == OP_FREE) begin
            if (addr % PAGE_BYTES != 0 || addr < {1'b0, region_low}
                    || addr >= {1'b0, region_high} || addr < base) begin
                rsp.status = STATUS_BAD_ADDR;
                return rsp;
            end
            idx = (addr - base) / PAGE_BYTES;
            if (idx >= NUM_PAGES) begin
                rsp.status = STATUS_BAD_ADDR;
                return rsp;
            end
            next_link[idx] = list_head[c];
            list_head[c]   = 16'(idx + 33'd1);
            rsp.status     = STATUS_OK;
            return rsp;
        end
        h = take_head(c);
        // own list empty: steal round-robin starting at the next cpu
        for (int j = 1; j < NUM_CPUS && h == 16'd0; j++) begin
            h = take_head((c + j) % NUM_CPUS);
            if (h != 16'd0) rsp.stolen = 1'b1;
        end
        if (h == 16'd0) begin
            rsp.status = STATUS_NO_PAGE;
        end else begin
            rsp.status     = STATUS_OK;
            rsp.alloc_addr = 32'(base + 33'(h - 16'd1) * PAGE_BYTES);
        end
        return rsp;
    endfunction

    always @(posedge aclk) begin
        out_t want;
        if (!aresetn) begin
            region_low  = '0;
            region_high = '0;
            foreach (list_head[i]) list_head[i] = '0;
            expected_results.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_REGION_LOW) region_low = cfg_wdata;
                else region_high = cfg_wdata;
            end
            if (s_valid && s_ready) expected_results.push_back(serve_request(s_data));
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: result with nothing pending: addr %h status %0d stolen %b",
                                 $time, m_data.alloc_addr, m_data.status, m_data.stolen);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_data.alloc_addr !== want.alloc_addr || m_data.status !== want.status
                            || m_data.stolen !== want.stolen) begin
                        if (mismatches < 10)
                            $display("%0t: expected addr %h status %0d stolen %b, got addr %h status %0d stolen %b",
                                     $time, want.alloc_addr, want.status, want.stolen,
                                     m_data.alloc_addr, m_data.status, m_data.stolen);
                        mismatches++;
                    end
                end
            end
        end
        pending_results = expected_results.size();
    end

endmodule

// File: bench/tb_per_cpu_page_free_list_allocator_top.sv
`timescale 1ns / 1ps

module tb_per_cpu_page_free_list_allocator_top;
    import pcpa_pkg::*;

    localparam int NUM_CPUS    = 8;
    localparam int NUM_PAGES   = 32768;
    localparam int PAGE_BYTES  = 4096;
    localparam int IDLE_PCT    = 24;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_ITEMS = 104;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_t         s_data;
    logic        m_valid;
    logic        m_ready;
    out_t        m_data;
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_wdata;
    int          mismatches;
    int          pending_results;

    logic [31:0] cur_low;
    logic [31:0] cur_high;
    int          fresh_page;
    logic [31:0] owned_pages [$];
    bit          track_owned;
    bit          no_gaps;
    int          items_sent;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    per_cpu_page_free_list_allocator_top #(
        .NUM_CPUS   (NUM_CPUS),
        .NUM_PAGES  (NUM_PAGES),
        .PAGE_BYTES (PAGE_BYTES)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    page_alloc_checker #(
        .NUM_CPUS   (NUM_CPUS),
        .NUM_PAGES  (NUM_PAGES),
        .PAGE_BYTES (PAGE_BYTES)
    ) i_page_alloc_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .mismatches      (mismatches),
        .pending_results (pending_results)
    );

    function automatic in_t request(input logic op, input logic [2:0] cpu,
                                    input logic [31:0] addr);
        in_t req;
        req.op        = op;
        req.cpu       = cpu;
        req.page_addr = addr;
        return req;
    endfunction

    function automatic logic [31:0] page_at(input logic [31:0] lo, input int idx);
        logic [32:0] base;
        base = ({1'b0, lo} + 33'(PAGE_BYTES - 1)) & ~33'(PAGE_BYTES - 1);
        return 32'(base + 33'(idx) * PAGE_BYTES);
    endfunction

    function automatic in_t random_request(input int alloc_pct);
        in_t req;
        int  pick;
        req.op        = OP_ALLOC;
        req.cpu       = 3'($urandom_range(NUM_CPUS - 1));
        req.page_addr = $urandom();
        if ($urandom_range(99) < alloc_pct) return req;
        req.op = OP_FREE;
        // frees lean towards two cpus so the others have to steal
        if ($urandom_range(1) == 1) req.cpu = 3'($urandom_range(1));
        pick = $urandom_range(99);
        if (pick < 3) begin
            req.page_addr = $urandom();
        end else if (pick < 6) begin
            req.page_addr = page_at(cur_low, fresh_page) | 32'($urandom_range(PAGE_BYTES - 1, 1));
        end else if (pick < 9) begin
            req.page_addr = page_at(cur_low, 0) - PAGE_BYTES;
        end else if (pick < 12) begin
            req.page_addr = ($urandom_range(1) == 1) ? {cur_high[31:12], 12'h000}
                                                     : page_at(cur_low, NUM_PAGES);
        end else if (owned_pages.size() != 0 && $urandom_range(99) < 60) begin
            pick          = $urandom_range(owned_pages.size() - 1);
            req.page_addr = owned_pages[pick];
            owned_pages.delete(pick);
        end else begin
            req.page_addr = page_at(cur_low, fresh_page);
            fresh_page++;
        end
        return req;
    endfunction

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic push_item(input in_t req);
        while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_results != 0) @(negedge aclk);
    endtask

    task automatic set_region(input logic [31:0] lo, input logic [31:0] hi);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_REGION_LOW;
        cfg_wdata <= lo;
        @(negedge aclk);
        cfg_index <= CFG_REGION_HIGH;
        cfg_wdata <= hi;
        @(negedge aclk);
        cfg_we   <= 1'b0;
        cur_low  = lo;
        cur_high = hi;
        owned_pages.delete();
    endtask

    task automatic run_phase(input logic [31:0] lo, input logic [31:0] hi, input int alloc_pct);
        set_region(lo, hi);
        repeat (PHASE_ITEMS) push_item(random_request(alloc_pct));
    endtask

    // pages handed out come back later as well-formed frees
    always @(posedge aclk) begin
        if (track_owned && m_valid && m_ready && m_data.status == STATUS_OK
                && m_data.alloc_addr != '0)
            owned_pages.push_back(m_data.alloc_addr);
    end

    initial begin : sink
        bit held;
        held = 1'b0;
        m_ready <= 1'b0;
        forever begin
            @(negedge aclk);
            if (!held && items_sent >= 400) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            m_ready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
            else quiet_cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin : stimulus
        logic [31:0] lo;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_REGION_LOW;
        cfg_wdata <= '0;
        cur_low   = '0;
        cur_high  = '0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // empty region out of reset
        push_item(request(OP_FREE, 3'd0, 32'h0000_1000));
        push_item(request(OP_ALLOC, 3'd7, 32'h0000_0000));

        set_region(32'h0000_1001, 32'hFFFF_FFFF);
        push_item(request(OP_FREE, 3'd0, page_at(cur_low, 0)));
        push_item(request(OP_FREE, 3'd0, page_at(cur_low, 1)));
        push_item(request(OP_FREE, 3'd3, page_at(cur_low, NUM_PAGES - 1)));
        // capacity, below region, misaligned, far out
        push_item(request(OP_FREE, 3'd5, page_at(cur_low, NUM_PAGES)));
        push_item(request(OP_FREE, 3'd1, 32'h0000_1000));
        push_item(request(OP_FREE, 3'd1, 32'h0000_2001));
        push_item(request(OP_FREE, 3'd2, 32'hFFFF_F000));
        push_item(request(OP_FREE, 3'd2, 32'hFFFF_FFFF));
        // lifo order, then steal, then nothing left
        push_item(request(OP_ALLOC, 3'd0, 32'h0000_0000));
        push_item(request(OP_ALLOC, 3'd0, 32'h0000_0000));
        push_item(request(OP_ALLOC, 3'd0, 32'h0000_0000));
        push_item(request(OP_ALLOC, 3'd7, 32'h0000_0000));
        // steal scan wraps past the top cpu
        push_item(request(OP_FREE, 3'd2, page_at(cur_low, 2)));
        push_item(request(OP_FREE, 3'd0, page_at(cur_low, 3)));
        push_item(request(OP_ALLOC, 3'd6, 32'h0000_0000));
        push_item(request(OP_ALLOC, 3'd6, 32'h0000_0000));
        // same page freed on two cpus goes unnoticed
        push_item(request(OP_FREE, 3'd4, page_at(cur_low, 4)));
        push_item(request(OP_FREE, 3'd5, page_at(cur_low, 4)));
        push_item(request(OP_ALLOC, 3'd4, 32'h0000_0000));
        push_item(request(OP_ALLOC, 3'd5, 32'h0000_0000));
        push_item(request(OP_ALLOC, 3'd4, 32'h0000_0000));
        push_item(request(OP_FREE, 3'd7, page_at(cur_low, 5)));
        push_item(request(OP_ALLOC, 3'd7, 32'hFFFF_FFFF));

        fresh_page  = 6;
        track_owned = 1'b1;
        run_phase(32'h0000_0000, 32'hFFFF_FFFF, 35);
        no_gaps = 1'b1;
        run_phase(32'h0000_3456, 32'hFFFF_FFFF, 65);
        no_gaps = 1'b0;
        lo = $urandom_range(32'h0FFF_FFFF);
        run_phase(lo, page_at(lo, fresh_page + 40), 50);
        run_phase(32'h0000_5000, 32'h0000_5000, 60);
        run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 50);
        run_phase(32'hFFFF_F000, 32'hFFFF_FFFF, 40);
        run_phase(32'h0000_0000, 32'h0000_0000, 50);
        run_phase(32'h0000_1000, 32'hFFFF_FFFF, 45);

        drain();
        repeat (20) @(negedge aclk);
        if (mismatches == 0 && pending_results == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
